/* rtl/core/polynomial_evaluator_defines.svh */
// assertion macros shared by the polynomial evaluator rtl
// each macro expects clk and arst_n in scope
`ifndef POLYNOMIAL_EVALUATOR_DEFINES_SVH
`define POLYNOMIAL_EVALUATOR_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define PE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent checked in the same cycle as the antecedent
`define PE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/core/polyev_pkg.sv */
package polyev_pkg;

	// sizes of the datapath
	localparam int MAX_DEGREE = 6;
	localparam int FRAC_BITS  = 16;
	localparam int WORD_W     = 32;
	localparam int PROD_W     = 2 * WORD_W;
	localparam int COEF_SLOTS = 7;
	localparam int CSEL_W     = $clog2(COEF_SLOTS);
	localparam int DEG_W      = 3;
	localparam int IDX_W      = 4;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] wide_t;
	typedef logic [DEG_W-1:0]         deg_t;
	typedef logic [IDX_W-1:0]         reg_idx_t;
	typedef logic [CSEL_W-1:0]        coef_sel_t;
	typedef word_t [COEF_SLOTS-1:0]   coef_arr_t;

	// register map
	localparam reg_idx_t REG_DEGREE    = IDX_W'(0);
	localparam reg_idx_t REG_COEF_0    = IDX_W'(1);
	localparam reg_idx_t REG_COEF_LAST = IDX_W'(COEF_SLOTS);

	// saturation limits
	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// running horner state between steps
	typedef struct packed {
		deg_t  deg;
		logic  ovf;
		word_t acc;
		word_t x;
	} horner_t;

	// state after the multiply half of a step
	typedef struct packed {
		deg_t  deg;
		logic  ovf;
		logic  on;
		word_t acc;
		word_t x;
		wide_t prod;
	} mul_t;

endpackage

/* rtl/core/polyev_regs.sv */
module polyev_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  polyev_pkg::reg_idx_t  cfg_index,
	input  polyev_pkg::word_t     cfg_data,
	output polyev_pkg::deg_t      degree,
	output polyev_pkg::coef_arr_t coef
);
	import polyev_pkg::*;

	deg_t      degree_q;
	coef_arr_t coef_q;
	coef_sel_t slot_off;

	assign slot_off = coef_sel_t'(cfg_index - REG_COEF_0);

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			coef_q   <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_DEGREE) begin
				degree_q <= cfg_data[DEG_W-1:0];
			end else if (cfg_index >= REG_COEF_0 && cfg_index <= REG_COEF_LAST) begin
				coef_q[slot_off] <= cfg_data;
			end
		end
	end

	// cap degree at the pipeline depth
	assign degree = (degree_q > deg_t'(MAX_DEGREE)) ? deg_t'(MAX_DEGREE) : degree_q;
	assign coef   = coef_q;

endmodule

/* rtl/core/polyev_mul.sv */
module polyev_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                in_valid,
	input  polyev_pkg::horner_t in_data,
	input  polyev_pkg::deg_t    coef_idx,
	output logic                out_valid,
	output polyev_pkg::mul_t    out_data
);
	import polyev_pkg::*;

	logic vld_s1;
	mul_t mul_s1;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_valid;
		end
	end

	// full product of accumulator and point
	always_ff @(posedge clk) begin
		if (advance) begin
			mul_s1.deg  <= in_data.deg;
			mul_s1.ovf  <= in_data.ovf;
			mul_s1.on   <= in_data.deg > coef_idx;
			mul_s1.acc  <= in_data.acc;
			mul_s1.x    <= in_data.x;
			mul_s1.prod <= $signed(in_data.acc) * $signed(in_data.x);
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = mul_s1;

endmodule

/* rtl/core/polyev_acc.sv */
`include "polynomial_evaluator_defines.svh"

module polyev_acc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                in_valid,
	input  polyev_pkg::mul_t    in_data,
	input  polyev_pkg::word_t   coef,
	output logic                out_valid,
	output polyev_pkg::horner_t out_data
);
	import polyev_pkg::*;

	logic    vld_s2;
	horner_t sum_s2;
	wide_t   shifted;
	wide_t   sum;
	logic    above;
	logic    below;
	word_t   acc_next;

	// floor shift, add coefficient, clamp to word range; a step not in use passes the accumulator through
	always_comb begin
		shifted = $signed(in_data.prod) >>> FRAC_BITS;
		sum     = shifted + wide_t'(coef);
		above   = sum > wide_t'(WORD_MAX);
		below   = sum < wide_t'(WORD_MIN);
		if (!in_data.on) begin
			acc_next = in_data.acc;
		end else if (above) begin
			acc_next = WORD_MAX;
		end else if (below) begin
			acc_next = WORD_MIN;
		end else begin
			acc_next = sum[WORD_W-1:0];
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= in_valid;
		end
	end

	// step result
	always_ff @(posedge clk) begin
		if (advance) begin
			sum_s2.deg <= in_data.deg;
			sum_s2.ovf <= in_data.ovf | (in_data.on & (above | below));
			sum_s2.acc <= acc_next;
			sum_s2.x   <= in_data.x;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = sum_s2;

	`PE_ASSERT_NEXT(a_bypass_holds, advance && in_valid && !in_data.on, out_data.acc == $past(in_data.acc), "idle step changed accumulator")
	`PE_ASSERT_NEXT(a_ovf_sticky, advance && in_valid && in_data.ovf, out_data.ovf, "overflow flag lost")
	`PE_ASSERT_NEXT(a_sat_bound, advance && in_valid && in_data.on && !in_data.ovf, !out_data.ovf || out_data.acc == WORD_MAX || out_data.acc == WORD_MIN, "overflow without clamp")
	`PE_ASSERT_NOW(a_deg0_clean, out_valid && out_data.deg == '0, !out_data.ovf, "degree zero item overflowed")

endmodule

/* rtl/core/polynomial_evaluator.sv */
// polynomial evaluator, horner form, signed q16.16
// configuration: write degree (index 0) and coef_0..coef_6 (index 1..7) through
// cfg_we / cfg_index / cfg_data while no request is in flight; other indexes are
// ignored, and a degree above the cap is treated as the cap
// input channel: in_valid / in_stall carries one point per request
// output channel: out_valid / out_stall carries value and overflow per request
// pipeline: one entry register, then per horner step a multiply stage and an
// add-and-clamp stage, the 32x32 multiplier setting the stage depth
// throughput: one request per cycle unless a stalled result holds the pipeline;
// every item runs the full pipeline and steps above its degree pass the
// accumulator through unchanged
// stall: a stalled result holds the whole pipeline, so in_stall rises in the
// same cycle and nothing is dropped or repeated
// reset: pipeline emptied, degree and all coefficients cleared to zero
module polynomial_evaluator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  polyev_pkg::reg_idx_t cfg_index,
	input  polyev_pkg::word_t    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  polyev_pkg::word_t    point,
	output logic                 out_valid,
	input  logic                 out_stall,
	output polyev_pkg::word_t    value,
	output logic                 overflow
);
	import polyev_pkg::*;

	deg_t      degree;
	coef_arr_t coef;
	logic      advance;
	logic      ent_vld_s1;
	horner_t   ent_s1;
	logic      vld_chain [MAX_DEGREE+1];
	horner_t   hrn_chain [MAX_DEGREE+1];

	polyev_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.degree    (degree),
		.coef      (coef)
	);

	// whole pipeline moves unless a finished result is held
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	// entry stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_s1 <= 1'b0;
		end else if (advance) begin
			ent_vld_s1 <= in_valid;
		end
	end

	// entry stage: start from the top coefficient in use
	always_ff @(posedge clk) begin
		if (advance) begin
			ent_s1.deg <= degree;
			ent_s1.ovf <= 1'b0;
			ent_s1.acc <= coef[degree];
			ent_s1.x   <= point;
		end
	end

	assign vld_chain[0] = ent_vld_s1;
	assign hrn_chain[0] = ent_s1;

	// one horner step per coefficient below the top
	for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_step
		logic mul_vld;
		mul_t mul_data;

		polyev_mul u_mul (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.in_valid  (vld_chain[j]),
			.in_data   (hrn_chain[j]),
			.coef_idx  (deg_t'(MAX_DEGREE - 1 - j)),
			.out_valid (mul_vld),
			.out_data  (mul_data)
		);

		polyev_acc u_acc (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.in_valid  (mul_vld),
			.in_data   (mul_data),
			.coef      (coef[MAX_DEGREE - 1 - j]),
			.out_valid (vld_chain[j+1]),
			.out_data  (hrn_chain[j+1])
		);
	end

	assign out_valid = vld_chain[MAX_DEGREE];
	assign value     = hrn_chain[MAX_DEGREE].acc;
	assign overflow  = hrn_chain[MAX_DEGREE].ovf;

endmodule
